// ===== rtl/mmks_pkg.sv =====
// package: sizes, codes and control/status bundles for the multi-method key sorter
package mmks_pkg;

  // storage size and widths
  localparam int DEPTH       = 64;
  localparam int KEY_W       = 32;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int STATUS_W    = 2;
  localparam int METHOD_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 2'd1;

  // method codes; anything above shell is invalid
  localparam logic [METHOD_W-1:0] METHOD_BUBBLE    = 3'd0;
  localparam logic [METHOD_W-1:0] METHOD_INSERTION = 3'd1;
  localparam logic [METHOD_W-1:0] METHOD_SELECTION = 3'd2;
  localparam logic [METHOD_W-1:0] METHOD_COMB      = 3'd3;
  localparam logic [METHOD_W-1:0] METHOD_SHELL     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_METHOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;
    logic close;
    logic align_step;
    logic emit_step;
    logic emit_err;
    logic desc;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic align_zero;
    logic rem_one;
  } dp_status_t;

endpackage

// ===== rtl/mmks_key_if.sv =====
// interface: input key channel
interface mmks_key_if;
  logic                       valid;
  logic                       ready;
  logic [mmks_pkg::KEY_W-1:0] key;
  logic                       last_key;

  modport source (output valid, output key, output last_key, input ready);
  modport sink (input valid, input key, input last_key, output ready);
endinterface

// ===== rtl/mmks_result_if.sv =====
// interface: sorted result channel
interface mmks_result_if;
  logic                          valid;
  logic                          ready;
  logic [mmks_pkg::KEY_W-1:0]    sorted_key;
  logic                          last_out;
  logic [mmks_pkg::STATUS_W-1:0] status;

  modport source (output valid, output sorted_key, output last_out, output status, input ready);
  modport sink (input valid, input sorted_key, input last_out, input status, output ready);
endinterface

// ===== rtl/multi_method_key_sorter.sv =====
// top level: multi-method key sorter, controller plus cell-row datapath
//
//   channel      dir   beat contents
//   key_in       in    key, last_key
//   sorted_out   out   sorted_key, last_out, status
//   cfg          in    cfg_we, cfg_index, cfg_data (write only)
//
// keys go into a sorted register row, one beat per cycle, while a set is collected.
// after the closing key: descending runs first shift the row up until the set fills the
// top cells, then one key leaves per cycle while the output is not stalled; input is
// held off from the closing beat until the last key of the run has been emitted.
// an invalid method gives a single error beat; input is held off during the run.
// rst is synchronous and clears counts, flags, state and config; a stalled output
// holds its beat and the row waits behind it.
module multi_method_key_sorter (
  input  logic                            clk,
  input  logic                            rst,
  mmks_key_if.sink                        key_in,
  mmks_result_if.source                   sorted_out,
  input  logic                            cfg_we,
  input  logic [mmks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmks_pkg::CFG_DATA_W-1:0] cfg_data
);

  mmks_pkg::ctrl_cmd_t  cmd;
  mmks_pkg::dp_status_t status;
  logic                 in_ready;

  assign key_in.ready = in_ready;

  // sequencing
  mmks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (key_in.valid),
    .in_last   (key_in.last_key),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and output register
  mmks_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .key        (key_in.key),
    .status     (status),
    .out_ready  (sorted_out.ready),
    .out_valid  (sorted_out.valid),
    .out_key    (sorted_out.sorted_key),
    .out_last   (sorted_out.last_out),
    .out_status (sorted_out.status)
  );

`ifndef SYNTHESIS
  // closing beat stops input on the next cycle
  a_close_blocks_input: assert property (@(posedge clk) disable iff (rst)
    key_in.valid && key_in.ready && key_in.last_key |=> !key_in.ready)
    else $error("input still ready after closing beat");

  // no input is taken while keys are being emitted
  a_emit_excludes_input: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> !key_in.ready)
    else $error("input ready during emission");

  // an error beat always ends its run
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    sorted_out.valid && (sorted_out.status == mmks_pkg::STATUS_BAD_METHOD)
      |-> sorted_out.last_out)
    else $error("error beat without last mark");
`endif

endmodule

// ===== rtl/mmks_datapath.sv =====
// datapath: sorted cell row, counters and output register
module mmks_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mmks_pkg::ctrl_cmd_t           cmd,
  input  logic [mmks_pkg::KEY_W-1:0]    key,
  output mmks_pkg::dp_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mmks_pkg::KEY_W-1:0]    out_key,
  output logic                          out_last,
  output logic [mmks_pkg::STATUS_W-1:0] out_status
);

  logic [mmks_pkg::KEY_W-1:0]    cells [mmks_pkg::DEPTH];
  logic [mmks_pkg::DEPTH-1:0]    gt;
  logic [mmks_pkg::COUNT_W-1:0]  count;
  logic [mmks_pkg::COUNT_W-1:0]  rem;
  logic [mmks_pkg::COUNT_W-1:0]  align_cnt;
  logic [mmks_pkg::COUNT_W-1:0]  close_n;
  logic                          ovf;
  logic                          full;
  logic                          dir;
  logic [mmks_pkg::STATUS_W-1:0] run_status;

  assign full = (count == mmks_pkg::COUNT_W'(mmks_pkg::DEPTH));

  // each held cell compares itself with the incoming key (row kept ascending)
  always_comb begin
    for (int i = 0; i < mmks_pkg::DEPTH; i++) begin
      gt[i] = (mmks_pkg::COUNT_W'(i) < count) && (cells[i] > key);
    end
  end

  // set size once the closing key has gone in
  assign close_n = full ? count : count + mmks_pkg::COUNT_W'(1);

  assign status.out_free   = !out_valid || out_ready;
  assign status.align_zero = (align_cnt == '0);
  assign status.rem_one    = (rem == mmks_pkg::COUNT_W'(1));

  // cell row: insert, shift towards the top, or shift out at either end
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      for (int i = 0; i < mmks_pkg::DEPTH; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (mmks_pkg::COUNT_W'(i) == count)) begin
          cells[i] <= key;
        end
      end
    end else if (cmd.align_step || (cmd.emit_step && dir)) begin
      for (int i = 1; i < mmks_pkg::DEPTH; i++) begin
        cells[i] <= cells[i - 1];
      end
    end else if (cmd.emit_step) begin
      for (int i = 0; i < mmks_pkg::DEPTH - 1; i++) begin
        cells[i] <= cells[i + 1];
      end
    end
  end

  // fill count, overflow flag and run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      rem        <= '0;
      align_cnt  <= '0;
      dir        <= 1'b0;
      run_status <= mmks_pkg::STATUS_OK;
    end else begin
      if (cmd.close) begin
        count      <= '0;
        ovf        <= 1'b0;
        rem        <= close_n;
        align_cnt  <= mmks_pkg::COUNT_W'(mmks_pkg::DEPTH) - close_n;
        dir        <= cmd.desc;
        run_status <= (ovf || full) ? mmks_pkg::STATUS_OVERFLOW : mmks_pkg::STATUS_OK;
      end else if (cmd.insert) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + mmks_pkg::COUNT_W'(1);
        end
      end
      if (cmd.align_step) begin
        align_cnt <= align_cnt - mmks_pkg::COUNT_W'(1);
      end
      if (cmd.emit_step) begin
        rem <= rem - mmks_pkg::COUNT_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_key    <= dir ? cells[mmks_pkg::DEPTH - 1] : cells[0];
      out_last   <= (rem == mmks_pkg::COUNT_W'(1));
      out_status <= run_status;
    end else if (cmd.emit_err) begin
      out_key    <= '0;
      out_last   <= 1'b1;
      out_status <= mmks_pkg::STATUS_BAD_METHOD;
    end
  end

endmodule

// ===== rtl/mmks_ctrl.sv =====
// controller: configuration registers and run sequencing state machine
module mmks_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mmks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_last,
  output logic                            in_ready,
  input  mmks_pkg::dp_status_t            status,
  output mmks_pkg::ctrl_cmd_t             cmd
);

  typedef enum logic [1:0] {
    COLLECT,
    ALIGN,
    EMIT,
    ERR
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [mmks_pkg::METHOD_W-1:0] method;
  logic                          descending;
  logic                          accept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      method     <= mmks_pkg::METHOD_BUBBLE;
      descending <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmks_pkg::REG_METHOD:     method     <= cfg_data;
        mmks_pkg::REG_DESCENDING: descending <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = (state == COLLECT) && in_valid && in_ready;

  // commands and next state
  always_comb begin
    cmd            = '0;
    cmd.desc       = descending;
    state_next     = state;
    unique case (state)
      COLLECT: begin
        cmd.insert = accept;
        if (accept && in_last) begin
          cmd.close = 1'b1;
          if (method > mmks_pkg::METHOD_SHELL) begin
            state_next = ERR;
          end else if (descending) begin
            state_next = ALIGN;
          end else begin
            state_next = EMIT;
          end
        end
      end
      ALIGN: begin
        if (status.align_zero) begin
          state_next = EMIT;
        end else begin
          cmd.align_step = 1'b1;
        end
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.rem_one) begin
            state_next = COLLECT;
          end
        end
      end
      ERR: begin
        if (status.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = COLLECT;
        end
      end
      default: state_next = COLLECT;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= COLLECT;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == COLLECT);
    end
  end

endmodule
